### rtl/tssl_pkg.sv
package tssl_pkg;

    localparam int CONFIRM_PACKETS_DEF = 10;
    localparam int WINDOW_DEPTH_DEF    = 4096;

    localparam logic [7:0]  SYNC_MARK  = 8'h47;
    localparam int          BASE_SIZE  = 188;
    localparam int          SIZE_STEP1 = 16;
    localparam int          SIZE_STEP2 = 20;
    localparam int          PCR_W      = 42;
    localparam int          CLK_W      = 25;
    localparam int          DVD_W      = 32 + CLK_W;
    localparam logic [CLK_W-1:0] PCR_CLOCK = 25'd27000000;
    localparam logic [8:0]  PCR_EXT_MUL = 9'd300;
    localparam int          PID_W      = 14;

    typedef enum logic [1:0] {
        EV_GAINED = 2'd0,
        EV_LOST   = 2'd1,
        EV_RATE   = 2'd2
    } event_t;

    typedef struct packed {
        event_t      ev;
        logic [7:0]  size;
        logic [7:0]  skip;
        logic [31:0] rate;
        logic        last;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOP,
        S_HUNT,
        S_SRD,
        S_SCMP,
        S_CHK0,
        S_PRD,
        S_PCAP,
        S_TRK,
        S_TRK2,
        S_MUL,
        S_DIV,
        S_DROP,
        S_DRAIN
    } state_t;

    function automatic logic [7:0] try_size(input logic [1:0] k);
        case (k)
            2'd0:    try_size = 8'(BASE_SIZE);
            2'd1:    try_size = 8'(BASE_SIZE + SIZE_STEP1);
            2'd2:    try_size = 8'(BASE_SIZE + SIZE_STEP2);
            default: try_size = 8'(BASE_SIZE);
        endcase
    endfunction

endpackage

### rtl/ts_sync_lock_and_rate.sv
// Transport stream sync lock and transport rate detector.
// Input channel: one stream byte per transfer on data_byte (in_valid/in_ready).
// Output channel: events (sync gained, sync lost, rate detected) with the locked
// packet size, the bytes skipped before the first locked packet and the rate in
// packets per second; last marks the final event caused by one input byte.
// Bytes go into a window memory with one registered read port; all work is done
// by a sequencer that reads that memory one byte at a time. While hunting, each
// size is tried by comparing bytes for sync marks, repeated for each new byte
// until lock or a 188-byte drop. Once locked, each packet is checked for its
// sync mark; until the rate is known, the packet header is also read for its
// PCR, and the 57-step divider runs once a rate can be computed.
// Events pass through a four-deep result queue; a stalled receiver holds the
// queue, and the sequencer waits only when the queue is full, so new bytes are
// still taken while earlier events wait. Reset returns to hunting with an empty
// window and the rate unknown; the window memory itself is not cleared.
module ts_sync_lock_and_rate
    import tssl_pkg::*;
#(
    parameter int CONFIRM_PACKETS = CONFIRM_PACKETS_DEF,
    parameter int WINDOW_DEPTH    = WINDOW_DEPTH_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  event_res,
    output logic [7:0]  locked_len,
    output logic [7:0]  skip_offset,
    output logic [31:0] rate,
    output logic        last
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int FW = $clog2(WINDOW_DEPTH + 1);
    localparam int JW = $clog2(CONFIRM_PACKETS + 1);
    localparam logic [FW-1:0] NEED0 = FW'(BASE_SIZE * (CONFIRM_PACKETS + 1));
    localparam logic [FW-1:0] NEED1 = FW'((BASE_SIZE + SIZE_STEP1) * (CONFIRM_PACKETS + 1));
    localparam logic [FW-1:0] NEED2 = FW'((BASE_SIZE + SIZE_STEP2) * (CONFIRM_PACKETS + 1));
    localparam logic [FW-1:0] DEPTH_F = FW'(WINDOW_DEPTH);

    state_t           state_reg, state_next;
    logic [FW-1:0]    fill_reg, fill_next;
    logic [AW-1:0]    head_reg, head_next;
    logic             locked_reg, locked_next;
    logic [7:0]       lsize_reg, lsize_next;
    logic [PID_W-1:0] pcr_pid_reg, pcr_pid_next;
    logic [PCR_W-1:0] first_pcr_reg, first_pcr_next;
    logic [31:0]      pkt_count_reg, pkt_count_next;
    logic [31:0]      rate_val_reg, rate_val_next;
    logic [1:0]       k_reg, k_next;
    logic [7:0]       off_i_reg, off_i_next;
    logic [JW-1:0]    j_reg, j_next;
    logic [AW-1:0]    cur_reg, cur_next;
    logic [3:0]       pidx_reg, pidx_next;
    logic [7:0]       pkt_reg [1:11];
    logic [PCR_W-1:0] pcr_val_reg, pcr_val_next;
    logic [PCR_W-1:0] diff_reg, diff_next;
    result_t          res_reg [0:2];
    result_t          res_new;
    logic             res_we;
    logic [1:0]       n_reg, n_next;
    logic [1:0]       didx_reg, didx_next;

    logic             wr_en, rd_en;
    logic [AW-1:0]    wr_addr, rd_addr, rd_off;
    logic [7:0]       rd_data;
    logic             push, fifo_full;
    result_t          push_data, out_data;
    logic             div_start, div_done;
    logic [DVD_W-1:0] div_q;
    logic [DVD_W-1:0] product;

    logic [7:0]       cur_size;
    logic [FW-1:0]    cur_need;
    logic             fill_short;
    logic [12:0]      pid;
    logic             has_pcr;
    logic [32:0]      pcr_base;
    logic [8:0]       pcr_ext;
    logic [31:0]      cnt_inc;
    logic             is_sync;
    logic             accept;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW+1)'(WINDOW_DEPTH))
        begin
            s = s - (AW+1)'(WINDOW_DEPTH);
        end
        wrap_add = s[AW-1:0];
    endfunction

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign is_sync  = (rd_data == SYNC_MARK);
    assign cur_size = try_size(k_reg);

    always_comb
    begin
        case (k_reg)
            2'd0:    cur_need = NEED0;
            2'd1:    cur_need = NEED1;
            default: cur_need = NEED2;
        endcase
    end

    assign fill_short = (fill_reg < cur_need);

    // packet header fields of the packet at the window head
    assign pid      = {pkt_reg[1][4:0], pkt_reg[2]};
    assign has_pcr  = pkt_reg[3][5] && (pkt_reg[4] != 8'd0) && pkt_reg[5][4];
    assign pcr_base = {pkt_reg[6], pkt_reg[7], pkt_reg[8], pkt_reg[9], pkt_reg[10][7]};
    assign pcr_ext  = {pkt_reg[10][0], pkt_reg[11]};
    assign cnt_inc  = (pkt_count_reg == 32'hFFFF_FFFF) ? pkt_count_reg : pkt_count_reg + 32'd1;
    assign product  = DVD_W'(pkt_count_reg) * DVD_W'(PCR_CLOCK);

    assign wr_addr  = wrap_add(head_reg, fill_reg[AW-1:0]);
    assign rd_addr  = wrap_add(head_reg, rd_off);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOP;
                end
            end
            S_LOOP:
            begin
                if (locked_reg)
                begin
                    state_next = (fill_reg < FW'(lsize_reg)) ? S_DRAIN : S_CHK0;
                end
                else
                begin
                    state_next = S_HUNT;
                end
            end
            S_HUNT:
            begin
                if (k_reg == 2'd3)
                begin
                    state_next = S_LOOP;
                end
                else if (fill_short)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    state_next = S_SRD;
                end
            end
            S_SRD:   state_next = S_SCMP;
            S_SCMP:
            begin
                if (is_sync && (j_reg == JW'(CONFIRM_PACKETS)))
                begin
                    state_next = S_LOOP;
                end
                else if (!is_sync && (off_i_reg == cur_size - 8'd1))
                begin
                    state_next = S_HUNT;
                end
                else
                begin
                    state_next = S_SRD;
                end
            end
            S_CHK0:
            begin
                if (!is_sync)
                begin
                    state_next = S_LOOP;
                end
                else if (rate_val_reg == 32'd0)
                begin
                    state_next = S_PRD;
                end
                else
                begin
                    state_next = S_DROP;
                end
            end
            S_PRD:   state_next = S_PCAP;
            S_PCAP:  state_next = (pidx_reg == 4'd11) ? S_TRK : S_PRD;
            S_TRK:   state_next = S_TRK2;
            S_TRK2:
            begin
                if (!pcr_pid_reg[PID_W-1] && has_pcr && (pid == pcr_pid_reg[12:0])
                    && (pcr_val_reg > first_pcr_reg))
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_DROP;
                end
            end
            S_MUL:   state_next = S_DIV;
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_DROP;
                end
            end
            S_DROP:  state_next = S_LOOP;
            S_DRAIN:
            begin
                if (n_reg == 2'd0)
                begin
                    state_next = S_IDLE;
                end
                else if (!fifo_full && (didx_reg == n_reg - 2'd1))
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        fill_next      = fill_reg;
        head_next      = head_reg;
        locked_next    = locked_reg;
        lsize_next     = lsize_reg;
        pcr_pid_next   = pcr_pid_reg;
        first_pcr_next = first_pcr_reg;
        pkt_count_next = pkt_count_reg;
        rate_val_next  = rate_val_reg;
        k_next         = k_reg;
        off_i_next     = off_i_reg;
        j_next         = j_reg;
        cur_next       = cur_reg;
        pidx_next      = pidx_reg;
        pcr_val_next   = pcr_val_reg;
        diff_next      = diff_reg;
        n_next         = n_reg;
        didx_next      = didx_reg;
        res_we         = 1'b0;
        res_new        = '{ev: EV_GAINED, size: 8'd0, skip: 8'd0, rate: 32'd0, last: 1'b0};
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_off         = '0;
        push           = 1'b0;
        push_data      = res_reg[didx_reg];
        div_start      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    n_next    = 2'd0;
                    didx_next = 2'd0;
                    // a byte arriving at a full window is ignored
                    if (fill_reg < DEPTH_F)
                    begin
                        wr_en     = 1'b1;
                        fill_next = fill_reg + FW'(1);
                    end
                end
            end
            S_LOOP:
            begin
                k_next = 2'd0;
                if (locked_reg)
                begin
                    rd_en = 1'b1;
                end
            end
            S_HUNT:
            begin
                if (k_reg == 2'd3)
                begin
                    // no size confirmed: drop one base packet and hunt again
                    head_next = wrap_add(head_reg, AW'(BASE_SIZE));
                    fill_next = fill_reg - FW'(BASE_SIZE);
                end
                else if (!fill_short)
                begin
                    off_i_next = 8'd0;
                    j_next     = '0;
                    cur_next   = '0;
                end
            end
            S_SRD:
            begin
                rd_en  = 1'b1;
                rd_off = cur_reg;
            end
            S_SCMP:
            begin
                if (is_sync)
                begin
                    if (j_reg == JW'(CONFIRM_PACKETS))
                    begin
                        head_next   = wrap_add(head_reg, AW'(off_i_reg));
                        fill_next   = fill_reg - FW'(off_i_reg);
                        locked_next = 1'b1;
                        lsize_next  = cur_size;
                        res_we      = 1'b1;
                        res_new.ev   = EV_GAINED;
                        res_new.size = cur_size;
                        res_new.skip = off_i_reg;
                    end
                    else
                    begin
                        j_next   = j_reg + JW'(1);
                        cur_next = cur_reg + AW'(cur_size);
                    end
                end
                else if (off_i_reg == cur_size - 8'd1)
                begin
                    k_next = k_reg + 2'd1;
                end
                else
                begin
                    off_i_next = off_i_reg + 8'd1;
                    j_next     = '0;
                    cur_next   = AW'(off_i_reg) + AW'(1);
                end
            end
            S_CHK0:
            begin
                pidx_next = 4'd1;
                if (!is_sync)
                begin
                    // lose lock; the packet stays in the window for hunting
                    locked_next    = 1'b0;
                    lsize_next     = 8'd0;
                    pcr_pid_next   = {1'b1, 13'd0};
                    first_pcr_next = '0;
                    pkt_count_next = '0;
                    rate_val_next  = '0;
                    res_we         = 1'b1;
                    res_new.ev     = EV_LOST;
                end
            end
            S_PRD:
            begin
                rd_en  = 1'b1;
                rd_off = AW'(pidx_reg);
            end
            S_PCAP:
            begin
                pidx_next = pidx_reg + 4'd1;
            end
            S_TRK:
            begin
                pcr_val_next = PCR_W'(pcr_base) * PCR_W'(PCR_EXT_MUL) + PCR_W'(pcr_ext);
            end
            S_TRK2:
            begin
                if (pcr_pid_reg[PID_W-1])
                begin
                    if (has_pcr)
                    begin
                        first_pcr_next = pcr_val_reg;
                        pcr_pid_next   = {1'b0, pid};
                    end
                end
                else
                begin
                    pkt_count_next = cnt_inc;
                    if (has_pcr && (pid == pcr_pid_reg[12:0]))
                    begin
                        if (pcr_val_reg > first_pcr_reg)
                        begin
                            diff_next = pcr_val_reg - first_pcr_reg;
                        end
                        else
                        begin
                            // non-increasing PCR: restart from this one
                            first_pcr_next = pcr_val_reg;
                            pkt_count_next = '0;
                        end
                    end
                end
            end
            S_MUL:
            begin
                div_start = 1'b1;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    rate_val_next  = (|div_q[DVD_W-1:32]) ? 32'hFFFF_FFFF : div_q[31:0];
                    res_we         = 1'b1;
                    res_new.ev     = EV_RATE;
                    res_new.size   = lsize_reg;
                    res_new.rate   = rate_val_next;
                end
            end
            S_DROP:
            begin
                head_next = wrap_add(head_reg, AW'(lsize_reg));
                fill_next = fill_reg - FW'(lsize_reg);
            end
            S_DRAIN:
            begin
                if ((n_reg != 2'd0) && !fifo_full)
                begin
                    push           = 1'b1;
                    push_data.last = (didx_reg == n_reg - 2'd1);
                    didx_next      = didx_reg + 2'd1;
                end
            end
            default:
            begin
            end
        endcase
        // at most three events per byte are kept
        if (res_we && (n_reg != 2'd3))
        begin
            n_next = n_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            head_reg      <= '0;
            locked_reg    <= 1'b0;
            lsize_reg     <= '0;
            pcr_pid_reg   <= {1'b1, 13'd0};
            first_pcr_reg <= '0;
            pkt_count_reg <= '0;
            rate_val_reg  <= '0;
            n_reg         <= '0;
            didx_reg      <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            head_reg      <= head_next;
            locked_reg    <= locked_next;
            lsize_reg     <= lsize_next;
            pcr_pid_reg   <= pcr_pid_next;
            first_pcr_reg <= first_pcr_next;
            pkt_count_reg <= pkt_count_next;
            rate_val_reg  <= rate_val_next;
            n_reg         <= n_next;
            didx_reg      <= didx_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_i_reg   <= off_i_next;
        j_reg       <= j_next;
        cur_reg     <= cur_next;
        pidx_reg    <= pidx_next;
        pcr_val_reg <= pcr_val_next;
        diff_reg    <= diff_next;
        if (state_reg == S_PCAP)
        begin
            pkt_reg[pidx_reg] <= rd_data;
        end
        if (res_we && (n_reg != 2'd3))
        begin
            res_reg[n_reg] <= res_new;
        end
    end

    tssl_window_ram #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .AW           (AW)
    ) u_window (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (data_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tssl_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (diff_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    tssl_result_fifo u_results (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign event_res   = out_data.ev;
    assign locked_len  = out_data.size;
    assign skip_offset = out_data.skip;
    assign rate        = out_data.rate;
    assign last        = out_data.last;

endmodule

### rtl/tssl_window_ram.sv
module tssl_window_ram
    import tssl_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int AW = $clog2(WINDOW_DEPTH)
)(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [0:WINDOW_DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/tssl_divider.sv
module tssl_divider
    import tssl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [PCR_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CW = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [PCR_W:0]   rem_reg, rem_next;
    logic [PCR_W-1:0] div_reg, div_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [PCR_W:0]   rem_sh;

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg[PCR_W-1:0], dvd_reg[DVD_W-1]};
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = CW'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // one restoring step: shift in a bit, subtract if it fits
            if (rem_sh >= {1'b0, div_reg})
            begin
                rem_next = rem_sh - {1'b0, div_reg};
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

### rtl/tssl_result_fifo.sv
module tssl_result_fifo
    import tssl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    result_t    slot [0:3];
    logic [1:0] wp_reg, wp_next;
    logic [1:0] rp_reg, rp_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;

    assign full      = (cnt_reg == 3'd4);
    assign out_valid = (cnt_reg != 3'd0);
    assign pop       = out_valid && out_ready;
    assign out_data  = slot[rp_reg];

    always_comb
    begin
        wp_next  = push ? wp_reg + 2'd1 : wp_reg;
        rp_next  = pop ? rp_reg + 2'd1 : rp_reg;
        cnt_next = cnt_reg + {2'b0, push} - {2'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot[wp_reg] <= push_data;
        end
    end

endmodule

### rtl/tssl_checker.sv
module tssl_checker
    import tssl_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  data_byte,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  event_res,
    input logic [7:0]  locked_len,
    input logic [7:0]  skip_offset,
    input logic [31:0] rate,
    input logic        last
);

    // hold a waiting byte
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(data_byte))
        else $error("waiting byte changed");

    // hold a stalled event
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(rate)
            && $stable(locked_len) && $stable(skip_offset) && $stable(last))
        else $error("stalled event changed");

    a_lost_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == EV_LOST) |-> (locked_len == 8'd0))
        else $error("sync lost with a packet size");

    a_skip_gain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res != EV_GAINED) |-> (skip_offset == 8'd0))
        else $error("skip offset outside sync gained");

    a_rate_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res != EV_RATE) |-> (rate == 32'd0))
        else $error("rate outside rate event");

endmodule

bind ts_sync_lock_and_rate tssl_checker u_tssl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_res   (event_res),
    .locked_len  (locked_len),
    .skip_offset (skip_offset),
    .rate        (rate),
    .last        (last)
);
